// ----- rtl/core/dsfp_pkg.sv -----
// shared types, constants and helpers of the dust sensor frame parser
package dsfp_pkg;

   // frame geometry
   localparam int FRAME_LEN = 32;
   localparam int POS_W     = 6;
   localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_LEN - 1);
   localparam logic [POS_W-1:0] CHECK_POS = POS_W'(FRAME_LEN - 2);
   localparam logic [POS_W-1:0] POS_HUNT  = POS_W'(0);
   localparam logic [POS_W-1:0] POS_HDR2  = POS_W'(1);
   localparam logic [POS_W-1:0] POS_BODY  = POS_W'(2);

   // register map, index is byte address / 4
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_HEADER_FIRST  = 3'd0;
   localparam logic [2:0] REG_HEADER_SECOND = 3'd1;
   localparam logic [2:0] REG_PM1_OFFSET    = 3'd2;
   localparam logic [2:0] REG_PM25_OFFSET   = 3'd3;
   localparam logic [2:0] REG_PM10_OFFSET   = 3'd4;

   // register reset values
   localparam logic [7:0] HEADER_FIRST_RST  = 8'h42;
   localparam logic [7:0] HEADER_SECOND_RST = 8'h4D;
   localparam logic [4:0] PM1_OFFSET_RST    = 5'd4;
   localparam logic [4:0] PM25_OFFSET_RST   = 5'd6;
   localparam logic [4:0] PM10_OFFSET_RST   = 5'd8;

   // configuration seen by the frame engine
   typedef struct packed {
      logic [7:0] header_first;
      logic [7:0] header_second;
      logic [4:0] pm1_offset;
      logic [4:0] pm25_offset;
      logic [4:0] pm10_offset;
   } cfg_type;

   // one finished frame handed to the output register
   typedef struct packed {
      logic        valid;
      logic [15:0] pm1_value;
      logic [15:0] pm25_value;
      logic [15:0] pm10_value;
      logic        frame_ok;
   } result_type;

   // drop a byte into the high or low half of a big-endian word
   function automatic logic [15:0] place_byte(
      input logic [15:0]      word,
      input logic [POS_W-1:0] pos,
      input logic [POS_W-1:0] off,
      input logic [7:0]       b
   );
      logic [15:0]      w;
      logic [POS_W-1:0] off_lo;
      w      = word;
      off_lo = off + POS_W'(1);
      if (pos == off) begin
         w[15:8] = b;
      end
      if (pos == off_lo) begin
         w[7:0] = b;
      end
      return w;
   endfunction

endpackage

// ----- rtl/core/dust_sensor_frame_parser_core.sv -----
// dust sensor frame parser top level
// a frame result reaches the output after its last byte transfer by way of the
// input byte register, then the result register
// throughput: one byte per cycle, unless a finished frame waits for the result register
// reset: synchronous, clears frame position, both valid flags and restores registers
module dust_sensor_frame_parser_core
   import dsfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,   // [15:0] pm1_value, [31:16] pm25_value, [47:32] pm10_value
   output logic [0:0]            rsp_tuser,   // [0] frame_ok
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   result_type res;
   logic       out_ready;

   dsfp_csr_regs u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dsfp_frame_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .out_ready  (out_ready),
      .res        (res)
   );

   dsfp_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .res        (res),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // a blocked frame result is held unchanged until the output frees up
   a_res_held: assert property (@(posedge clock) disable iff (reset)
      (res.valid && !out_ready) |=> (res.valid && $stable(res.pm1_value)
                                     && $stable(res.frame_ok)))
      else $error("frame result changed while stalled");

   // an output transfer only appears after the engine finished a frame
   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(res.valid))
      else $error("result appeared without a finished frame");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

// ----- rtl/core/dsfp_csr_regs.sv -----
// configuration register file with an apb-style access port
module dsfp_csr_regs
   import dsfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[4:2];

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_HEADER_FIRST:  cfg_in.header_first  = csr_pwdata[7:0];
            REG_HEADER_SECOND: cfg_in.header_second = csr_pwdata[7:0];
            REG_PM1_OFFSET:    cfg_in.pm1_offset    = csr_pwdata[4:0];
            REG_PM25_OFFSET:   cfg_in.pm25_offset   = csr_pwdata[4:0];
            REG_PM10_OFFSET:   cfg_in.pm10_offset   = csr_pwdata[4:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first  <= HEADER_FIRST_RST;
         cfg_ff.header_second <= HEADER_SECOND_RST;
         cfg_ff.pm1_offset    <= PM1_OFFSET_RST;
         cfg_ff.pm25_offset   <= PM25_OFFSET_RST;
         cfg_ff.pm10_offset   <= PM10_OFFSET_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_HEADER_FIRST:  csr_prdata = {24'd0, cfg_ff.header_first};
         REG_HEADER_SECOND: csr_prdata = {24'd0, cfg_ff.header_second};
         REG_PM1_OFFSET:    csr_prdata = {27'd0, cfg_ff.pm1_offset};
         REG_PM25_OFFSET:   csr_prdata = {27'd0, cfg_ff.pm25_offset};
         REG_PM10_OFFSET:   csr_prdata = {27'd0, cfg_ff.pm10_offset};
         default:           csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/dsfp_frame_engine.sv -----
// input byte register, header hunt, frame position, sum and reading capture
module dsfp_frame_engine
   import dsfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       out_ready,
   output result_type res
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      sum_ff, sum_in;
   logic [15:0]      pm1_ff, pm1_in;
   logic [15:0]      pm25_ff, pm25_in;
   logic [15:0]      pm10_ff, pm10_in;
   logic [15:0]      check_ff, check_in;
   logic             take;
   logic             emit;
   logic             advance;
   logic             req_xfer;
   logic [15:0]      sum_base, pm1_base, pm25_base, pm10_base, check_base;

   // the held byte finishes a frame on the last position
   assign emit       = (pos_ff == LAST_POS);
   assign advance    = in_valid_ff & ~(emit & ~out_ready);
   assign req_tready = ~in_valid_ff | advance;
   assign req_xfer   = req_tvalid & req_tready;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // byte is part of a frame unless a header test fails
   always_comb begin
      case (pos_ff)
         POS_HUNT: take = (in_byte_ff == cfg.header_first);
         POS_HDR2: take = (in_byte_ff == cfg.header_second);
         default:  take = 1'b1;
      endcase
   end

   // a new frame starts from cleared sum and captures
   assign sum_base   = (pos_ff == POS_HUNT) ? 16'd0 : sum_ff;
   assign pm1_base   = (pos_ff == POS_HUNT) ? 16'd0 : pm1_ff;
   assign pm25_base  = (pos_ff == POS_HUNT) ? 16'd0 : pm25_ff;
   assign pm10_base  = (pos_ff == POS_HUNT) ? 16'd0 : pm10_ff;
   assign check_base = (pos_ff == POS_HUNT) ? 16'd0 : check_ff;

   // next frame state
   always_comb begin
      sum_in   = sum_ff;
      pm1_in   = pm1_ff;
      pm25_in  = pm25_ff;
      pm10_in  = pm10_ff;
      check_in = check_ff;
      pos_in   = pos_ff;
      if (take) begin
         pm1_in   = place_byte(pm1_base, pos_ff, {1'b0, cfg.pm1_offset}, in_byte_ff);
         pm25_in  = place_byte(pm25_base, pos_ff, {1'b0, cfg.pm25_offset}, in_byte_ff);
         pm10_in  = place_byte(pm10_base, pos_ff, {1'b0, cfg.pm10_offset}, in_byte_ff);
         check_in = place_byte(check_base, pos_ff, CHECK_POS, in_byte_ff);
         sum_in   = (pos_ff < CHECK_POS) ? sum_base + {8'd0, in_byte_ff} : sum_base;
         pos_in   = emit ? POS_HUNT : pos_ff + POS_W'(1);
      end else begin
         pos_in = POS_HUNT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pos_ff      <= POS_HUNT;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         sum_ff   <= sum_in;
         pm1_ff   <= pm1_in;
         pm25_ff  <= pm25_in;
         pm10_ff  <= pm10_in;
         check_ff <= check_in;
      end
   end

   // finished frame from the updated captures
   assign res.valid      = in_valid_ff & emit;
   assign res.pm1_value  = pm1_in;
   assign res.pm25_value = pm25_in;
   assign res.pm10_value = pm10_in;
   assign res.frame_ok   = (sum_in == check_in);

endmodule

// ----- rtl/core/dsfp_out_stage.sv -----
// result register on the output stream
module dsfp_out_stage
   import dsfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  result_type  res,
   output logic        out_ready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   output logic [0:0]  rsp_tuser
);

   logic        out_valid_ff, out_valid_in;
   logic [47:0] data_ff;
   logic        ok_ff;
   logic        load;

   assign out_ready = ~out_valid_ff | rsp_tready;
   assign load      = res.valid & out_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // payload captured on load
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= {res.pm10_value, res.pm25_value, res.pm1_value};
         ok_ff   <= res.frame_ok;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = ok_ff;

endmodule
